@@ src/tmbt_pkg.sv @@
// Shared types, constants and codes for the tempo map beat-to-time block.
`timescale 1ns / 1ps
package tmbt_pkg;

  localparam int unsigned DEF_MAX_SEGMENTS = 64;

  localparam int BEAT_W  = 32;
  localparam int TEMPO_W = 16;
  localparam int SEC_W   = 40;
  localparam int DUR_W   = 41;
  localparam int SPB_W   = 26;
  localparam int SLOPE_W = 48;
  localparam int DVD_W   = 58;
  localparam int DVS_W   = 32;
  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 111;
  localparam int TERM_W  = 51;
  localparam int LIN_W   = 44;

  // 960 * 2^16: sixty seconds over a Q12.4 tempo, result in Q10.16
  localparam logic [SPB_W-1:0] SPB_NUM = 26'd62914560;
  localparam logic [SPB_W-1:0] SPB_ONE = 26'd65536;
  localparam logic [SEC_W-1:0] SEC_MAX = '1;
  localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << 47;
  localparam logic [TERM_W-1:0] TERM_MAX = TERM_W'(1) << 50;

  typedef enum logic [1:0] {
    REQ_BEGIN   = 2'd0,
    REQ_APPEND  = 2'd1,
    REQ_CONVERT = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TEMPO = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_SPB_DIV, S_APP_CHECK, S_SLOPE_DIV, S_WR_NEW,
    S_SRCH, S_SEG_RD, S_LIN, S_DD, S_DD_LATCH, S_QM, S_TERM, S_SUM, S_FINISH
  } state_e;

  typedef struct packed {
    req_e                      kind;
    logic [BEAT_W-1:0]         beat;
    logic signed [BEAT_W-1:0]  beat_duration;
    logic [TEMPO_W-1:0]        tempo;
    logic                      beat_zero;
    logic                      tempo_zero;
    logic                      dur_neg;
    logic [BEAT_W:0]           end_beat;
  } cmd_t;

  typedef struct packed {
    logic [BEAT_W-1:0]         beat_base;
    logic [SPB_W-1:0]          spb;
    logic signed [SLOPE_W-1:0] slope;
    logic [SEC_W-1:0]          time_base;
  } seg_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ src/tmbt_if.sv @@
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
interface tmbt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] beat;
  logic signed [31:0] beat_duration;
  logic [15:0] tempo;
  modport source (output valid, req_type, beat, beat_duration, tempo, input ready);
  modport sink (input valid, req_type, beat, beat_duration, tempo, output ready);
endinterface

interface tmbt_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] time_start;
  logic signed [40:0] time_duration;
  logic [1:0]  status;
  modport source (output valid, time_start, time_duration, status, input ready);
  modport sink (input valid, time_start, time_duration, status, output ready);
endinterface

@@ src/tmbt_front.sv @@
// Front end: takes request words, classifies them and queues commands.
`timescale 1ns / 1ps
module tmbt_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  tmbt_in_if.sink        in_i,
  input  logic           pop_i,
  output logic           cmd_valid_o,
  output tmbt_pkg::cmd_t cmd_o
);

  tmbt_pkg::cmd_t q_mem [2];
  tmbt_pkg::cmd_t cls;
  logic           wp_q, rp_q;
  logic [1:0]     cnt_q;
  logic           push;
  logic [31:0]    dur_mag;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];

  always_comb begin
    dur_mag = in_i.beat_duration[31] ? (~in_i.beat_duration + 32'd1) : in_i.beat_duration;
    cls.kind          = tmbt_pkg::req_e'(in_i.req_type);
    cls.beat          = in_i.beat;
    cls.beat_duration = in_i.beat_duration;
    cls.tempo         = in_i.tempo;
    cls.beat_zero     = (in_i.beat == '0);
    cls.tempo_zero    = (in_i.tempo == '0);
    cls.dur_neg       = in_i.beat_duration[31];
    cls.end_beat      = {1'b0, in_i.beat} + {1'b0, dur_mag};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

@@ src/tmbt_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tmbt_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmbt_pkg::div_req_t req_i,
  output tmbt_pkg::div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(tmbt_pkg::DVD_W + 1);

  logic [tmbt_pkg::DVD_W-1:0] dvd_q;
  logic [tmbt_pkg::DVS_W-1:0] rem_q, dvs_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       busy_q, done_q;
  logic [tmbt_pkg::DVS_W:0]   rem_sh, rem_sub;
  logic                       ge;

  assign rem_sh  = {rem_q, dvd_q[tmbt_pkg::DVD_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tmbt_pkg::DVD_W-2:0], ge};
      rem_q <= ge ? rem_sub[tmbt_pkg::DVS_W-1:0] : rem_sh[tmbt_pkg::DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(tmbt_pkg::DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/tmbt_back.sv @@
// Back end: segment table, map updates and beat-to-time warping.
`timescale 1ns / 1ps
module tmbt_back #(
  parameter int unsigned MAX_SEGMENTS = tmbt_pkg::DEF_MAX_SEGMENTS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  tmbt_pkg::cmd_t     cmd_i,
  output logic               pop_o,
  output tmbt_pkg::div_req_t div_req_o,
  input  tmbt_pkg::div_rsp_t div_rsp_i,
  tmbt_out_if.source         out_o
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W = $clog2(MAX_SEGMENTS);

  tmbt_pkg::state_e  state_q, state_d;
  tmbt_pkg::seg_t    mem [MAX_SEGMENTS];
  tmbt_pkg::seg_t    rd_q, last_q, seg_q, mem_wdata;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;

  tmbt_pkg::cmd_t    cmd_q;
  tmbt_pkg::status_e status_q;
  logic              valid_q, out_valid_q, phase_q, cmpv_q;
  logic [CNT_W-1:0]  seg_cnt_q, i_q, cnt_m1;
  logic [IDX_W-1:0]  k_q, prev_i_q, last_idx;
  logic [39:0]       res_start_q, start_t_q, tb_q;
  logic signed [40:0] res_dur_q, dur_raw, dur_val;
  logic [32:0]       b_q, diff_q, seg_diff;
  logic [25:0]       spb_new_q, app_mag;
  logic [43:0]       lin_q;
  logic [63:0]       dd_q;
  logic [110:0]      acc_q, acc_add, acc_r;
  logic [2:0]        qcnt_q;
  logic [50:0]       term_q, term_val;
  logic [65:0]       p_q;
  logic [66:0]       lin_sum, tb_r;
  logic [32:0]       mul_a, mul_b;
  logic [31:0]       app_span, d_cap;
  logic signed [26:0] app_dspb, dspb_neg;
  logic              beat_lt, beat_eq, full, go;
  logic [43:0]       tb_sum;
  logic [39:0]       tb_sat, t_clamp;
  logic [46:0]       sl_mag, slope_mag;
  logic [47:0]       slope_neg, slope_val;
  logic signed [53:0] t_sum;

  // ---------------------------------------------------------------- datapath
  assign cnt_m1   = seg_cnt_q - 1'b1;
  assign last_idx = cnt_m1[IDX_W-1:0];
  assign go       = cmd_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o    = (state_q == tmbt_pkg::S_IDLE) && go;

  assign beat_lt  = cmd_q.beat < last_q.beat_base;
  assign beat_eq  = cmd_q.beat == last_q.beat_base;
  assign full     = seg_cnt_q == CNT_W'(MAX_SEGMENTS);
  assign app_span = cmd_q.beat - last_q.beat_base;
  assign app_dspb = $signed({1'b0, spb_new_q}) - $signed({1'b0, last_q.spb});
  assign dspb_neg = -app_dspb;
  assign app_mag  = app_dspb[26] ? dspb_neg[25:0] : app_dspb[25:0];

  assign sl_mag    = (|div_rsp_i.quotient[57:47]) ? '1 : div_rsp_i.quotient[46:0];
  assign slope_val = app_dspb[26] ? -{1'b0, sl_mag} : {1'b0, sl_mag};

  assign tb_r   = {1'b0, p_q} + 67'd65536;
  assign tb_sum = {4'b0, last_q.time_base} + {1'b0, tb_r[59:17]};
  assign tb_sat = (|tb_sum[43:40]) ? tmbt_pkg::SEC_MAX : tb_sum[39:0];

  assign seg_diff  = b_q - {1'b0, rd_q.beat_base};
  assign d_cap     = diff_q[32] ? '1 : diff_q[31:0];
  assign lin_sum   = {1'b0, p_q} + 67'd32768;
  assign slope_neg = -seg_q.slope;
  assign slope_mag = seg_q.slope[47] ? slope_neg[46:0] : seg_q.slope[46:0];

  assign acc_r    = acc_q + tmbt_pkg::ACC_HALF;
  assign term_val = (|acc_r[110:98]) ? tmbt_pkg::TERM_MAX : {1'b0, acc_r[97:48]};

  always_comb begin
    t_sum = $signed({14'b0, seg_q.time_base}) + $signed({10'b0, lin_q});
    if (seg_q.slope[47]) t_sum = t_sum - $signed({3'b0, term_q});
    else                 t_sum = t_sum + $signed({3'b0, term_q});
    if (t_sum[53])           t_clamp = '0;
    else if (|t_sum[52:40])  t_clamp = tmbt_pkg::SEC_MAX;
    else                     t_clamp = t_sum[39:0];
  end

  assign dur_raw = $signed({1'b0, t_clamp}) - $signed({1'b0, start_t_q});
  assign dur_val = cmd_q.dur_neg ? -dur_raw : dur_raw;

  // partial product issued one step earlier
  always_comb begin
    case (qcnt_q)
      3'd2:    acc_add = 111'(p_q) << 32;
      3'd3:    acc_add = 111'(p_q) << 24;
      3'd4:    acc_add = 111'(p_q) << 56;
      default: acc_add = 111'(p_q);
    endcase
  end

  // ----------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tmbt_pkg::S_INIT: state_d = tmbt_pkg::S_IDLE;
      tmbt_pkg::S_IDLE: if (go) state_d = tmbt_pkg::S_DISPATCH;
      tmbt_pkg::S_DISPATCH: begin
        unique case (cmd_q.kind)
          tmbt_pkg::REQ_BEGIN:
            state_d = (!cmd_q.beat_zero || cmd_q.tempo_zero) ? tmbt_pkg::S_FINISH
                                                              : tmbt_pkg::S_SPB_DIV;
          tmbt_pkg::REQ_APPEND:
            state_d = (!valid_q || cmd_q.tempo_zero) ? tmbt_pkg::S_FINISH
                                                     : tmbt_pkg::S_SPB_DIV;
          tmbt_pkg::REQ_CONVERT:
            state_d = valid_q ? tmbt_pkg::S_SRCH : tmbt_pkg::S_FINISH;
          default: state_d = tmbt_pkg::S_FINISH;
        endcase
      end
      tmbt_pkg::S_SPB_DIV: if (div_rsp_i.done) begin
        state_d = (cmd_q.kind == tmbt_pkg::REQ_BEGIN) ? tmbt_pkg::S_FINISH
                                                      : tmbt_pkg::S_APP_CHECK;
      end
      tmbt_pkg::S_APP_CHECK:
        state_d = (beat_lt || beat_eq || full) ? tmbt_pkg::S_FINISH : tmbt_pkg::S_SLOPE_DIV;
      tmbt_pkg::S_SLOPE_DIV: if (div_rsp_i.done) state_d = tmbt_pkg::S_WR_NEW;
      tmbt_pkg::S_WR_NEW:   state_d = tmbt_pkg::S_FINISH;
      tmbt_pkg::S_SRCH:     if (i_q >= seg_cnt_q) state_d = tmbt_pkg::S_SEG_RD;
      tmbt_pkg::S_SEG_RD:   state_d = tmbt_pkg::S_LIN;
      tmbt_pkg::S_LIN:      state_d = tmbt_pkg::S_DD;
      tmbt_pkg::S_DD:       state_d = tmbt_pkg::S_DD_LATCH;
      tmbt_pkg::S_DD_LATCH: state_d = tmbt_pkg::S_QM;
      tmbt_pkg::S_QM:       if (qcnt_q == 3'd4) state_d = tmbt_pkg::S_TERM;
      tmbt_pkg::S_TERM:     state_d = tmbt_pkg::S_SUM;
      tmbt_pkg::S_SUM:      state_d = phase_q ? tmbt_pkg::S_FINISH : tmbt_pkg::S_SRCH;
      tmbt_pkg::S_FINISH:   state_d = tmbt_pkg::S_IDLE;
      default:              state_d = tmbt_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------- memory, mul, divider
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '{beat_base: '0, spb: tmbt_pkg::SPB_ONE, slope: '0, time_base: '0};
    mem_raddr = last_idx;
    mul_a     = '0;
    mul_b     = '0;
    div_req_o = '{start: 1'b0, dividend: '0, divisor: '0};
    unique case (state_q)
      tmbt_pkg::S_INIT: mem_we = 1'b1;
      tmbt_pkg::S_DISPATCH: begin
        if (cmd_q.kind == tmbt_pkg::REQ_BEGIN && (!cmd_q.beat_zero || cmd_q.tempo_zero)) begin
          mem_we = 1'b1;
        end
        if ((cmd_q.kind == tmbt_pkg::REQ_BEGIN && cmd_q.beat_zero && !cmd_q.tempo_zero) ||
            (cmd_q.kind == tmbt_pkg::REQ_APPEND && valid_q && !cmd_q.tempo_zero)) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {32'b0, tmbt_pkg::SPB_NUM} + {43'b0, cmd_q.tempo[15:1]};
          div_req_o.divisor  = {16'b0, cmd_q.tempo};
        end
      end
      tmbt_pkg::S_SPB_DIV: begin
        if (div_rsp_i.done && cmd_q.kind == tmbt_pkg::REQ_BEGIN) begin
          mem_we        = 1'b1;
          mem_wdata.spb = div_rsp_i.quotient[25:0];
        end
      end
      tmbt_pkg::S_APP_CHECK: begin
        mul_a = 33'({1'b0, last_q.spb} + {1'b0, spb_new_q});
        mul_b = {1'b0, app_span};
        if (!beat_lt && beat_eq) begin
          mem_we        = 1'b1;
          mem_waddr     = last_idx;
          mem_wdata     = last_q;
          mem_wdata.spb = spb_new_q;
        end else if (!beat_lt && !full) begin
          div_req_o.start    = 1'b1;
          div_req_o.dividend = {1'b0, app_mag, 31'b0} + {27'b0, app_span[31:1]};
          div_req_o.divisor  = app_span;
        end
      end
      tmbt_pkg::S_SLOPE_DIV: begin
        mul_a = 33'({1'b0, last_q.spb} + {1'b0, spb_new_q});
        mul_b = {1'b0, app_span};
        if (div_rsp_i.done) begin
          mem_we          = 1'b1;
          mem_waddr       = last_idx;
          mem_wdata       = last_q;
          mem_wdata.slope = slope_val;
        end
      end
      tmbt_pkg::S_WR_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = seg_cnt_q[IDX_W-1:0];
        mem_wdata = '{beat_base: cmd_q.beat, spb: spb_new_q, slope: '0, time_base: tb_q};
      end
      tmbt_pkg::S_SRCH:   mem_raddr = i_q[IDX_W-1:0];
      tmbt_pkg::S_SEG_RD: mem_raddr = k_q;
      tmbt_pkg::S_LIN: begin
        mul_a = {7'b0, rd_q.spb};
        mul_b = seg_diff;
      end
      tmbt_pkg::S_DD: begin
        mul_a = {1'b0, d_cap};
        mul_b = {1'b0, d_cap};
      end
      tmbt_pkg::S_QM: begin
        case (qcnt_q)
          3'd0: begin mul_a = {9'b0, slope_mag[23:0]};  mul_b = {1'b0, dd_q[31:0]};  end
          3'd1: begin mul_a = {9'b0, slope_mag[23:0]};  mul_b = {1'b0, dd_q[63:32]}; end
          3'd2: begin mul_a = {10'b0, slope_mag[46:24]}; mul_b = {1'b0, dd_q[31:0]};  end
          3'd3: begin mul_a = {10'b0, slope_mag[46:24]}; mul_b = {1'b0, dd_q[63:32]}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_q <= mem[mem_raddr];
    p_q  <= mul_a * mul_b;
  end

  // ------------------------------------------------------ working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      tmbt_pkg::S_IDLE: if (go) cmd_q <= cmd_i;
      tmbt_pkg::S_DISPATCH: begin
        phase_q     <= 1'b0;
        b_q         <= {1'b0, cmd_q.beat};
        i_q         <= CNT_W'(1);
        k_q         <= '0;
        cmpv_q      <= 1'b0;
        if (cmd_q.kind == tmbt_pkg::REQ_CONVERT && !valid_q) begin
          res_start_q <= {8'b0, cmd_q.beat};
          res_dur_q   <= {{9{cmd_q.beat_duration[31]}}, cmd_q.beat_duration};
        end else begin
          res_start_q <= '0;
          res_dur_q   <= '0;
        end
        if (cmd_q.kind == tmbt_pkg::REQ_BEGIN && !cmd_q.beat_zero) begin
          status_q <= tmbt_pkg::ST_ORDER;
        end else if (cmd_q.tempo_zero && (cmd_q.kind == tmbt_pkg::REQ_BEGIN ||
                     (cmd_q.kind == tmbt_pkg::REQ_APPEND && valid_q))) begin
          status_q <= tmbt_pkg::ST_TEMPO;
        end else begin
          status_q <= tmbt_pkg::ST_OK;
        end
      end
      tmbt_pkg::S_SPB_DIV: if (div_rsp_i.done) begin
        spb_new_q <= div_rsp_i.quotient[25:0];
        last_q    <= rd_q;
      end
      tmbt_pkg::S_APP_CHECK: begin
        if (beat_lt)            status_q <= tmbt_pkg::ST_ORDER;
        else if (!beat_eq && full) status_q <= tmbt_pkg::ST_FULL;
      end
      tmbt_pkg::S_SLOPE_DIV: if (div_rsp_i.done) tb_q <= tb_sat;
      tmbt_pkg::S_SRCH: begin
        if (cmpv_q && ({1'b0, rd_q.beat_base} <= b_q)) k_q <= prev_i_q;
        if (i_q < seg_cnt_q) begin
          prev_i_q <= i_q[IDX_W-1:0];
          cmpv_q   <= 1'b1;
          i_q      <= i_q + 1'b1;
        end else begin
          cmpv_q <= 1'b0;
        end
      end
      tmbt_pkg::S_LIN: begin
        seg_q  <= rd_q;
        diff_q <= seg_diff;
      end
      tmbt_pkg::S_DD: lin_q <= lin_sum[59:16];
      tmbt_pkg::S_DD_LATCH: begin
        dd_q   <= p_q[63:0];
        acc_q  <= '0;
        qcnt_q <= '0;
      end
      tmbt_pkg::S_QM: begin
        qcnt_q <= qcnt_q + 1'b1;
        if (qcnt_q != 3'd0) acc_q <= acc_q + acc_add;
      end
      tmbt_pkg::S_TERM: term_q <= term_val;
      tmbt_pkg::S_SUM: begin
        if (!phase_q) begin
          start_t_q   <= t_clamp;
          res_start_q <= t_clamp;
          phase_q     <= 1'b1;
          b_q         <= cmd_q.end_beat;
          i_q         <= CNT_W'(1);
          k_q         <= '0;
          cmpv_q      <= 1'b0;
        end else begin
          res_dur_q <= dur_val;
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmbt_pkg::S_INIT;
      valid_q     <= 1'b1;
      seg_cnt_q   <= CNT_W'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tmbt_pkg::S_FINISH) out_valid_q <= 1'b1;
      else if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;
      if (state_q == tmbt_pkg::S_DISPATCH) begin
        if (cmd_q.kind == tmbt_pkg::REQ_BEGIN) begin
          seg_cnt_q <= CNT_W'(1);
          valid_q   <= cmd_q.beat_zero && !cmd_q.tempo_zero;
        end
        if (cmd_q.kind == tmbt_pkg::REQ_APPEND && cmd_q.tempo_zero) valid_q <= 1'b0;
      end
      if (state_q == tmbt_pkg::S_APP_CHECK && (beat_lt || (!beat_eq && full))) begin
        valid_q <= 1'b0;
      end
      if (state_q == tmbt_pkg::S_WR_NEW) seg_cnt_q <= seg_cnt_q + 1'b1;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.time_start    = res_start_q;
  assign out_o.time_duration = res_dur_q;
  assign out_o.status        = status_q;

  // ------------------------------------------------------------ assertions
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_cnt_q != '0 && seg_cnt_q <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp_i.done |-> (state_q == tmbt_pkg::S_SPB_DIV || state_q == tmbt_pkg::S_SLOPE_DIV))
    else $error("divider finished outside a wait state");

  a_seg_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmbt_pkg::S_SEG_RD) |-> (CNT_W'(k_q) < seg_cnt_q))
    else $error("segment search beyond table");

  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == tmbt_pkg::S_FINISH))
    else $error("result raised outside finish");

endmodule

@@ src/tempo_map_beat_to_time.sv @@
// Top level of the tempo map beat-to-time warp.
//
//  port    dir  modport  word
//  in_i    in   sink     req_type, beat, beat_duration, tempo
//  out_o   out  source   time_start, time_duration, status
//
//  One word at a time in the back end; a two-entry command queue and the
//  result register let the input side run ahead by two words.
//  Begin runs the shared divider once, append up to twice (tempo, then
//  slope). Convert runs the linear segment search twice, for start and end
//  beat; it reads one table entry per cycle. Reset writes table entry 0.
//  A stalled result holds the back end only; the queue keeps accepting until it is full.
`timescale 1ns / 1ps
module tempo_map_beat_to_time #(
  parameter int unsigned MAX_SEGMENTS = tmbt_pkg::DEF_MAX_SEGMENTS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tmbt_in_if.sink    in_i,
  tmbt_out_if.source out_o
);

  logic               cmd_valid, pop;
  tmbt_pkg::cmd_t     cmd;
  tmbt_pkg::div_req_t div_req;
  tmbt_pkg::div_rsp_t div_rsp;

  tmbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pop_i       (pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  tmbt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tmbt_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_o       (out_o)
  );

endmodule

@@ tb/sv/tempo_map_beat_to_time_test.sv @@
// Self-checking testbench for the tempo map beat-to-time warp.
`timescale 1ns / 1ps
module tempo_map_beat_to_time_test;

  localparam int          NSEG        = int'(tmbt_pkg::DEF_MAX_SEGMENTS);
  localparam int          N_ITEMS     = 1650;
  localparam int          QUIET_AFTER = 1450;
  localparam longint      CYCLE_LIMIT = 3000000;
  localparam logic [31:0] BEAT_ONE    = 32'h0001_0000;

  typedef struct {
    tmbt_pkg::req_e           kind;
    logic [31:0]              beat;
    logic signed [31:0]       dur;
    logic [15:0]              tempo;
  } word_t;

  typedef struct {
    logic [39:0]              start;
    logic signed [40:0]       dur;
    tmbt_pkg::status_e        st;
  } timing_t;

  logic clk_i;
  logic rst_ni;

  tmbt_in_if  in_if ();
  tmbt_out_if out_if ();

  tempo_map_beat_to_time i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  word_t   pending_words[$];
  timing_t expected_timings[$];
  int      n_sent;
  int      n_errors;
  longint  n_cycles;

  // tempo map copy
  logic [31:0]        map_beat[NSEG];
  logic [25:0]        map_spb[NSEG];
  longint             map_slope[NSEG];
  logic [39:0]        map_tbase[NSEG];
  int                 map_count;
  bit                 map_ok;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [25:0] spb_for(logic [15:0] tempo);
    longint unsigned t;
    t = tempo;
    return 26'((64'd62914560 + t / 2) / t);
  endfunction

  function automatic void map_clear();
    for (int i = 0; i < NSEG; i++) begin
      map_beat[i]  = '0;
      map_spb[i]   = '0;
      map_slope[i] = 0;
      map_tbase[i] = '0;
    end
    map_spb[0] = tmbt_pkg::SPB_ONE;
    map_count  = 1;
    map_ok     = 1'b1;
  endfunction

  function automatic tmbt_pkg::status_e map_append(logic [31:0] beat, logic [15:0] tempo);
    int                last;
    logic [25:0]       spb;
    longint unsigned   span, mag, tb;
    longint            dspb, slope;
    last = map_count - 1;
    if (tempo == 0) begin
      map_ok = 1'b0;
      return tmbt_pkg::ST_TEMPO;
    end
    if (beat < map_beat[last]) begin
      map_ok = 1'b0;
      return tmbt_pkg::ST_ORDER;
    end
    spb = spb_for(tempo);
    if (beat == map_beat[last]) begin
      map_spb[last] = spb;
      return tmbt_pkg::ST_OK;
    end
    if (map_count >= NSEG) begin
      map_ok = 1'b0;
      return tmbt_pkg::ST_FULL;
    end
    span  = 64'(beat) - 64'(map_beat[last]);
    dspb  = longint'(64'(spb)) - longint'(64'(map_spb[last]));
    mag   = dspb < 0 ? -dspb : dspb;
    mag   = ((mag << 31) + span / 2) / span;
    slope = mag > 64'h7FFF_FFFF_FFFF ? 64'h7FFF_FFFF_FFFF : mag;
    map_slope[last] = dspb < 0 ? -slope : slope;
    tb = 64'(map_tbase[last])
         + (((64'(map_spb[last]) + 64'(spb)) * span + 64'd65536) >> 17);
    if (tb > 64'(tmbt_pkg::SEC_MAX)) tb = 64'(tmbt_pkg::SEC_MAX);
    map_beat[map_count]  = beat;
    map_spb[map_count]   = spb;
    map_slope[map_count] = 0;
    map_tbase[map_count] = tb[39:0];
    map_count++;
    return tmbt_pkg::ST_OK;
  endfunction

  function automatic longint warp_beat(longint unsigned b);
    int              k;
    longint unsigned diff, d, mag, term;
    longint          t;
    logic [127:0]    prod;
    k = 0;
    for (int i = 1; i < map_count; i++)
      if (64'(map_beat[i]) <= b) k = i;
    diff = b - 64'(map_beat[k]);
    t = longint'(64'(map_tbase[k])) + longint'((64'(map_spb[k]) * diff + 64'd32768) >> 16);
    if (map_slope[k] != 0) begin
      d    = diff > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : diff;
      mag  = map_slope[k] < 0 ? -map_slope[k] : map_slope[k];
      prod = 128'(mag) * 128'(d * d) + (128'd1 << 47);
      prod = prod >> 48;
      term = prod > (128'd1 << 50) ? (64'd1 << 50) : prod[63:0];
      t    = map_slope[k] < 0 ? t - longint'(term) : t + longint'(term);
    end
    if (t < 0) t = 0;
    if (t > longint'(64'(tmbt_pkg::SEC_MAX))) t = longint'(64'(tmbt_pkg::SEC_MAX));
    return t;
  endfunction

  function automatic timing_t predict_timing(word_t w);
    timing_t         r;
    longint          s, e, d;
    longint unsigned m;
    r.start = '0;
    r.dur   = '0;
    r.st    = tmbt_pkg::ST_OK;
    case (w.kind)
      tmbt_pkg::REQ_BEGIN: begin
        map_clear();
        if (w.beat != 0) begin
          map_ok = 1'b0;
          r.st = tmbt_pkg::ST_ORDER;
        end else if (w.tempo == 0) begin
          map_ok = 1'b0;
          r.st = tmbt_pkg::ST_TEMPO;
        end else begin
          map_spb[0] = spb_for(w.tempo);
        end
      end
      tmbt_pkg::REQ_APPEND: begin
        if (map_ok) r.st = map_append(w.beat, w.tempo);
      end
      tmbt_pkg::REQ_CONVERT: begin
        d = w.dur;
        if (!map_ok) begin
          r.start = 40'(w.beat);
          r.dur   = 41'(d);
        end else begin
          m = d < 0 ? -d : d;
          s = warp_beat(64'(w.beat));
          e = warp_beat(64'(w.beat) + m);
          r.start = 40'(s);
          r.dur   = d < 0 ? 41'(s - e) : 41'(e - s);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_word(tmbt_pkg::req_e kind, logic [31:0] beat,
                                   logic [31:0] dur, logic [15:0] tempo);
    word_t w;
    w.kind  = kind;
    w.beat  = beat;
    w.dur   = dur;
    w.tempo = tempo;
    pending_words.push_back(w);
  endfunction

  function automatic logic [15:0] rand_tempo();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom_range(1, 40));
      1:       return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  function automatic void add_random_map();
    int          n_pts, n_conv;
    logic [31:0] b, step, top;
    n_pts = $urandom_range(0, 19) == 0 ? $urandom_range(60, 66) : $urandom_range(0, 6);
    add_word(tmbt_pkg::REQ_BEGIN, '0, $urandom, rand_tempo());
    b = '0;
    for (int i = 0; i < n_pts; i++) begin
      step = $urandom_range(0, 7) == 0 ? 32'd0 : 32'($urandom_range(1, 32'h0100_0000));
      if ($urandom_range(0, 29) == 0) step = $urandom_range(1, 32'h3000_0000);
      if (32'hFFFF_FFFF - b < step) step = 0;
      b += step;
      add_word(tmbt_pkg::REQ_APPEND, b, $urandom, rand_tempo());
    end
    top = b + 32'h0400_0000 < b ? 32'hFFFF_FFFF : b + 32'h0400_0000;
    n_conv = $urandom_range(2, 10);
    for (int i = 0; i < n_conv; i++) begin
      case ($urandom_range(0, 5))
        0:       add_word(tmbt_pkg::REQ_CONVERT, $urandom, $urandom, 16'($urandom));
        1:       add_word(tmbt_pkg::REQ_CONVERT, $urandom_range(0, top), $urandom,
                          16'($urandom));
        default: add_word(tmbt_pkg::REQ_CONVERT, $urandom_range(0, top),
                          32'(int'($urandom_range(0, 32'h0200_0000)) -
                              int'(32'h0100_0000)), 16'($urandom));
      endcase
    end
  endfunction

  function automatic void add_noise();
    tmbt_pkg::req_e k;
    k = tmbt_pkg::req_e'($urandom_range(0, 3));
    add_word(k, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h0100_0000),
             $urandom, $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom));
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h (word %0d)", what, got, want, n_errors);
    n_errors++;
  endtask

  // request driver
  int  src_idle;
  bit  in_accept;
  always @(posedge clk_i) begin
    word_t w;
    bit    offer;
    if (rst_ni) begin
      n_cycles++;
      in_accept = in_if.valid && in_if.ready;
      if (in_accept) begin
        w = pending_words.pop_front();
        expected_timings.push_back(predict_timing(w));
        n_sent++;
      end
      if (src_idle > 0) begin
        src_idle--;
        offer = 1'b0;
      end else if (n_sent < QUIET_AFTER && $urandom_range(0, 9) == 0) begin
        src_idle = $urandom_range(0, 14);
        offer = 1'b0;
      end else begin
        offer = pending_words.size() > 0;
      end
      if (!in_accept && in_if.valid) offer = 1'b1;
      in_if.valid <= offer;
      if (offer) begin
        w = pending_words[0];
        in_if.req_type      <= w.kind;
        in_if.beat          <= w.beat;
        in_if.beat_duration <= w.dur;
        in_if.tempo         <= w.tempo;
      end
    end
  end

  // long receiver hold-off
  int  hold_cycles;
  bit  hold_done;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_sent >= 300) begin
        hold_done   <= 1'b1;
        hold_cycles <= 600;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end
    end
  end

  // result monitor
  int  snk_idle;
  always @(posedge clk_i) begin
    timing_t want;
    bit      take;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_timings.size() == 0) begin
          report_mismatch("unexpected word", out_if.status, 0);
        end else begin
          want = expected_timings.pop_front();
          if (out_if.time_start !== want.start)
            report_mismatch("time_start", out_if.time_start, want.start);
          if (out_if.time_duration !== want.dur)
            report_mismatch("time_duration", out_if.time_duration, want.dur);
          if (out_if.status !== want.st)
            report_mismatch("status", out_if.status, want.st);
        end
      end
      if (hold_cycles > 0) begin
        take = 1'b0;
      end else if (snk_idle > 0) begin
        snk_idle--;
        take = 1'b0;
      end else if (n_sent < QUIET_AFTER && $urandom_range(0, 7) == 0) begin
        snk_idle = $urandom_range(0, 14);
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      out_if.ready <= take;
    end
  end

  always @(posedge clk_i) begin
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", n_cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.req_type      = tmbt_pkg::REQ_NONE;
    in_if.beat          = '0;
    in_if.beat_duration = '0;
    in_if.tempo         = '0;
    out_if.ready        = 1'b0;
    n_sent = 0; n_errors = 0; n_cycles = 0;
    src_idle = 0; snk_idle = 0; hold_cycles = 0; hold_done = 1'b0;
    map_clear();

    // directed: identity map, error paths, edges
    add_word(tmbt_pkg::REQ_CONVERT, 32'h0003_8000, 32'h0001_0000, '0);
    add_word(tmbt_pkg::REQ_CONVERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
    add_word(tmbt_pkg::REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    add_word(tmbt_pkg::REQ_BEGIN, 32'd5, '0, 16'd960);
    add_word(tmbt_pkg::REQ_CONVERT, 32'h1234_5678, 32'h8000_0000, '0);
    add_word(tmbt_pkg::REQ_APPEND, BEAT_ONE, '0, 16'd960);
    add_word(tmbt_pkg::REQ_BEGIN, '0, '0, 16'd0);
    add_word(tmbt_pkg::REQ_BEGIN, '0, '0, 16'd1);
    add_word(tmbt_pkg::REQ_APPEND, 32'd4 * BEAT_ONE, '0, 16'hFFFF);
    add_word(tmbt_pkg::REQ_APPEND, 32'd4 * BEAT_ONE, '0, 16'd1920);
    add_word(tmbt_pkg::REQ_APPEND, 32'd8 * BEAT_ONE, '0, 16'd480);
    add_word(tmbt_pkg::REQ_CONVERT, 32'd2 * BEAT_ONE, 32'hFFFE_0000, '0);
    add_word(tmbt_pkg::REQ_CONVERT, 32'd6 * BEAT_ONE, 32'h0003_0000, '0);
    add_word(tmbt_pkg::REQ_CONVERT, 32'hFFFF_0000, 32'h7FFF_FFFF, '0);
    add_word(tmbt_pkg::REQ_CONVERT, '0, 32'h8000_0000, '0);
    add_word(tmbt_pkg::REQ_APPEND, 32'd9 * BEAT_ONE, '0, 16'd0);
    add_word(tmbt_pkg::REQ_APPEND, 32'd10 * BEAT_ONE, '0, 16'd960);
    add_word(tmbt_pkg::REQ_BEGIN, '0, '0, 16'd960);
    add_word(tmbt_pkg::REQ_APPEND, 32'd3 * BEAT_ONE, '0, 16'd960);
    add_word(tmbt_pkg::REQ_APPEND, 32'd2 * BEAT_ONE, '0, 16'd960);
    add_word(tmbt_pkg::REQ_CONVERT, 32'd2 * BEAT_ONE, 32'd1, '0);
    add_word(tmbt_pkg::REQ_BEGIN, '0, '0, 16'd960);
    for (int i = 1; i <= 64; i++)
      add_word(tmbt_pkg::REQ_APPEND, 32'(i) * BEAT_ONE, '0, 16'(960 + 16 * i));
    add_word(tmbt_pkg::REQ_CONVERT, 32'd70 * BEAT_ONE, 32'd5, '0);

    while (pending_words.size() < N_ITEMS) begin
      if ($urandom_range(0, 9) == 0) add_noise();
      else add_random_map();
    end

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || expected_timings.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tmbt_pkg.sv
src/tmbt_if.sv
src/tmbt_front.sv
src/tmbt_div.sv
src/tmbt_back.sv
src/tempo_map_beat_to_time.sv
tb/sv/tempo_map_beat_to_time_test.sv
